FILE: sv/pdb_pkg.sv
// ----------------------------------------------------------------------------
// pdb_pkg
// Types, tag codes, entry codes and terminal value tables shared by the
// data object list related data builder.
// ----------------------------------------------------------------------------
package pdb_pkg;

	localparam int VAL_W   = 48;
	localparam int NUM_VAL = 8;
	localparam int ADDR_W  = 3;
	localparam int IDX_W   = 4;

	typedef logic [VAL_W-1:0]  value_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [3:0]        entry_t;

	// parser phase
	typedef enum logic [1:0] {
		PH_TAG1 = 2'd0,
		PH_TAG2 = 2'd1,
		PH_LEN  = 2'd2
	} phase_t;

	// entry codes, entry n > 0 lives at memory address n-1
	localparam entry_t E_ZERO = 4'd0;
	localparam entry_t E_TTI  = 4'd1;
	localparam entry_t E_TTQ  = 4'd2;
	localparam entry_t E_AMT  = 4'd3;
	localparam entry_t E_CTRY = 4'd4;
	localparam entry_t E_CURR = 4'd5;
	localparam entry_t E_DATE = 4'd6;
	localparam entry_t E_UN   = 4'd7;
	localparam entry_t E_MTI  = 4'd8;

	// register indexes
	localparam logic [IDX_W-1:0] R_TTI  = 4'd0;
	localparam logic [IDX_W-1:0] R_TTQ  = 4'd1;
	localparam logic [IDX_W-1:0] R_AMT  = 4'd2;
	localparam logic [IDX_W-1:0] R_CTRY = 4'd3;
	localparam logic [IDX_W-1:0] R_CURR = 4'd4;
	localparam logic [IDX_W-1:0] R_DATE = 4'd5;
	localparam logic [IDX_W-1:0] R_UN   = 4'd6;
	localparam logic [IDX_W-1:0] R_MTI  = 4'd7;

	// tags
	localparam logic [7:0]  T_DATE = 8'h9A;
	localparam logic [7:0]  T_TVR  = 8'h95;
	localparam logic [7:0]  T_TYPE = 8'h9C;
	localparam logic [7:0]  T_TCH  = 8'h98;
	localparam logic [15:0] T_TTI  = 16'h9F59;
	localparam logic [15:0] T_TTQ  = 16'h9F66;
	localparam logic [15:0] T_AMT  = 16'h9F02;
	localparam logic [15:0] T_CTRY = 16'h9F1A;
	localparam logic [15:0] T_CURR = 16'h5F2A;
	localparam logic [15:0] T_UN   = 16'h9F37;
	localparam logic [15:0] T_MTI  = 16'h9F58;

	// reset values, left aligned so byte k of a run is bits [47-8k -: 8]
	localparam value_t RESET_VAL [NUM_VAL] = '{
		48'hC88000_000000,
		48'h79004080_0000,
		48'h000000100000,
		48'h0124_00000000,
		48'h0124_00000000,
		48'h190101_000000,
		48'h823DDE7A_0000,
		48'h01_0000000000
	};

	typedef struct packed {
		logic   wr_en;
		addr_t  wr_addr;
		value_t wr_data;
		logic   rd_en;
		addr_t  rd_addr;
	} mem_req_t;

	// {known, entry} for a first tag byte
	function automatic logic [4:0] one_byte_entry(input logic [7:0] b);
		logic [4:0] r;
		unique case (b)
			T_DATE:                 r = {1'b1, E_DATE};
			T_TVR, T_TYPE, T_TCH:   r = {1'b1, E_ZERO};
			default:                r = {1'b0, E_ZERO};
		endcase
		return r;
	endfunction

	function automatic entry_t two_byte_entry(input logic [15:0] tag);
		entry_t r;
		unique case (tag)
			T_TTI:   r = E_TTI;
			T_TTQ:   r = E_TTQ;
			T_AMT:   r = E_AMT;
			T_CTRY:  r = E_CTRY;
			T_CURR:  r = E_CURR;
			T_UN:    r = E_UN;
			T_MTI:   r = E_MTI;
			default: r = E_ZERO;
		endcase
		return r;
	endfunction

	// left align a written value by its byte size, dropping bits above it
	function automatic value_t align_value(input logic [IDX_W-1:0] idx, input value_t d);
		value_t r;
		unique case (idx)
			R_TTI, R_DATE: r = {d[23:0], 24'h0};
			R_TTQ, R_UN:   r = {d[31:0], 16'h0};
			R_AMT:         r = d;
			R_CTRY, R_CURR: r = {d[15:0], 32'h0};
			R_MTI:         r = {d[7:0], 40'h0};
			default:       r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/pdb_value_mem.sv
// ----------------------------------------------------------------------------
// pdb_value_mem
// Terminal value store: one write and one registered read per cycle; an
// entry never written reads as its reset value.
// ----------------------------------------------------------------------------
module pdb_value_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  pdb_pkg::mem_req_t req,
	output pdb_pkg::value_t   rdata
);
	import pdb_pkg::*;

	value_t             mem [NUM_VAL];
	logic [NUM_VAL-1:0] valid_q;
	value_t             rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= valid_q[req.rd_addr] ? mem[req.rd_addr] : RESET_VAL[req.rd_addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/pdol_data_builder.sv
// ----------------------------------------------------------------------------
// pdol_data_builder
// Builds related data for a data object list, one value byte per word out.
// ----------------------------------------------------------------------------
// tag bytes and zero lengths: parser stays idle, next word accepted right after
// length byte of n: accepting it issues the value memory read, ST_READ loads the
// shift register, then min(n, MAX_RUN) bytes leave at one byte per cycle when out_ready is high
// one item is in flight at a time
// reset: parser back to the tag phase, all values return to their defaults
module pdol_data_builder #(
	parameter int MAX_RUN = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                list_byte,
	input  logic                      list_end,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                data_byte,
	output logic                      last_of_run,
	output logic                      list_done,
	output logic                      length_clamped,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [pdb_pkg::IDX_W-1:0] cfg_index,
	input  logic [pdb_pkg::VAL_W-1:0] cfg_data
);
	import pdb_pkg::*;

	localparam int CW = $clog2(MAX_RUN + 1);
	localparam logic [8:0]    MAX_RUN_W = 9'(MAX_RUN);
	localparam logic [CW-1:0] MAX_RUN_C = CW'(MAX_RUN);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t          state_q;
	phase_t          phase_q;
	logic [7:0]      first_tag_q;
	entry_t          entry_q;
	logic [CW-1:0]   cnt_q;
	value_t          shreg_q;
	logic            end_q;
	logic            clamp_q;
	logic            zero_q;

	mem_req_t        req;
	value_t          rdata;
	logic            in_acc;
	logic            out_acc;
	logic            over;
	logic [CW-1:0]   len;
	logic [4:0]      one_e;

	pdb_value_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_valid = (state_q == ST_EMIT);
	assign out_acc   = out_valid && out_ready;

	assign over  = {1'b0, list_byte} > MAX_RUN_W;
	assign len   = over ? MAX_RUN_C : list_byte[CW-1:0];
	assign one_e = one_byte_entry(list_byte);

	always_comb begin
		req.wr_en   = cfg_valid && (cfg_index < IDX_W'(NUM_VAL));
		req.wr_addr = cfg_index[ADDR_W-1:0];
		req.wr_data = align_value(cfg_index, cfg_data);
		req.rd_en   = in_acc && (phase_q == PH_LEN);
		req.rd_addr = ADDR_W'(entry_q - 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_TAG1;
			first_tag_q <= '0;
			entry_q     <= E_ZERO;
			cnt_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (phase_q)
							PH_LEN: begin
								phase_q <= PH_TAG1;
								cnt_q   <= len;
								if (len != '0) begin
									state_q <= ST_READ;
								end
							end
							PH_TAG2: begin
								entry_q <= two_byte_entry({first_tag_q, list_byte});
								phase_q <= list_end ? PH_TAG1 : PH_LEN;
							end
							default: begin
								first_tag_q <= list_byte;
								if (one_e[4]) begin
									entry_q <= one_e[3:0];
								end
								if (list_end) begin
									phase_q <= PH_TAG1;
								end else begin
									phase_q <= one_e[4] ? PH_LEN : PH_TAG2;
								end
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_acc) begin
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// run payload
	always_ff @(posedge clk) begin
		if (in_acc && (phase_q == PH_LEN)) begin
			end_q   <= list_end;
			clamp_q <= over;
			zero_q  <= (entry_q == E_ZERO);
		end
		if (state_q == ST_READ) begin
			shreg_q <= zero_q ? '0 : rdata;
		end else if (out_acc) begin
			// bytes past the value size shift in as zeros
			shreg_q <= {shreg_q[VAL_W-9:0], 8'h00};
		end
	end

	assign data_byte      = shreg_q[VAL_W-1 -: 8];
	assign last_of_run    = (cnt_q == CW'(1));
	assign list_done      = end_q;
	assign length_clamped = clamp_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open together");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cnt_q != '0))
		else $error("word offered with empty run count");

	a_read_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_EMIT))
		else $error("memory read not followed by emit");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_of_run) |=> in_ready)
		else $error("run did not end after last word");

endmodule

FILE: tb/sv/pdol_data_checker.sv
// ----------------------------------------------------------------------------
// pdol_data_checker
// Watches the list, config and data channels of the related data builder,
// keeps its own copy of the parser and terminal values, predicts the value
// bytes of every run and compares each accepted data word field by field.
// ----------------------------------------------------------------------------
module pdol_data_checker #(
	parameter int MAX_RUN = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [7:0]                list_byte,
	input  logic                      list_end,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [7:0]                data_byte,
	input  logic                      last_of_run,
	input  logic                      list_done,
	input  logic                      length_clamped,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [pdb_pkg::IDX_W-1:0] cfg_index,
	input  logic [pdb_pkg::VAL_W-1:0] cfg_data,
	output int                        fail_count,
	output int                        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import pdb_pkg::*;

	typedef struct {
		logic [7:0] value;
		logic       last;
		logic       done;
		logic       clamped;
	} run_byte_t;

	// terminal values kept right aligned
	localparam value_t DEFAULT_VALUE [NUM_VAL] = '{
		48'hC88000, 48'h79004080, 48'h000000100000, 48'h0124,
		48'h0124, 48'h190101, 48'h823DDE7A, 48'h01
	};

	run_byte_t  expected_bytes [$];
	value_t     term_value [NUM_VAL];
	phase_t     phase;
	logic [7:0] tag_hi;
	entry_t     entry;

	function automatic int unsigned value_size(input logic [IDX_W-1:0] ri);
		int unsigned n;
		case (ri)
			R_TTI, R_DATE: n = 3;
			R_TTQ, R_UN:   n = 4;
			R_AMT:         n = 6;
			R_CTRY, R_CURR: n = 2;
			default:       n = 1;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] value_byte(input entry_t ent, input int unsigned k);
		logic [IDX_W-1:0] ri;
		int unsigned n;
		value_t v;
		if (ent == E_ZERO || ent > E_MTI)
			return 8'h00;
		// entry n is served by register n-1
		ri = ent - 4'd1;
		v = term_value[ri[ADDR_W-1:0]];
		n = value_size(ri);
		if (k >= n)
			return 8'h00;
		return v[8*(n-1-k) +: 8];
	endfunction

	function automatic entry_t pair_entry(input logic [15:0] tag);
		entry_t r;
		case (tag)
			T_TTI:   r = E_TTI;
			T_TTQ:   r = E_TTQ;
			T_AMT:   r = E_AMT;
			T_CTRY:  r = E_CTRY;
			T_CURR:  r = E_CURR;
			T_UN:    r = E_UN;
			T_MTI:   r = E_MTI;
			default: r = E_ZERO;
		endcase
		return r;
	endfunction

	task automatic predict_word(input logic [7:0] b, input logic e);
		int unsigned len;
		logic clamp;
		run_byte_t r;
		case (phase)
			PH_LEN: begin
				len = 32'(b);
				clamp = 1'b0;
				if (len > MAX_RUN) begin
					len = MAX_RUN;
					clamp = 1'b1;
				end
				for (int unsigned k = 0; k < len; k++) begin
					r.value = value_byte(entry, k);
					r.last = (k + 1 == len);
					r.done = e;
					r.clamped = clamp;
					expected_bytes = {expected_bytes, r};
				end
				phase = PH_TAG1;
			end
			PH_TAG2: begin
				entry = pair_entry({tag_hi, b});
				phase = PH_LEN;
			end
			default: begin
				tag_hi = b;
				case (b)
					T_DATE: begin
						entry = E_DATE;
						phase = PH_LEN;
					end
					T_TVR, T_TYPE, T_TCH: begin
						entry = E_ZERO;
						phase = PH_LEN;
					end
					default: phase = PH_TAG2;
				endcase
			end
		endcase
		// list end drops whatever entry was open
		if (e)
			phase = PH_TAG1;
	endtask

	task automatic check_byte();
		run_byte_t x;
		if (expected_bytes.size() == 0) begin
			$error("data_byte %h arrived with no run byte expected", data_byte);
			fail_count++;
			return;
		end
		x = expected_bytes.pop_front();
		if (data_byte !== x.value) begin
			$error("data_byte: expected %h, actual %h", x.value, data_byte);
			fail_count++;
		end
		if (last_of_run !== x.last) begin
			$error("last_of_run: expected %b, actual %b", x.last, last_of_run);
			fail_count++;
		end
		if (list_done !== x.done) begin
			$error("list_done: expected %b, actual %b", x.done, list_done);
			fail_count++;
		end
		if (length_clamped !== x.clamped) begin
			$error("length_clamped: expected %b, actual %b", x.clamped, length_clamped);
			fail_count++;
		end
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_TAG1;
			tag_hi = 8'h00;
			entry = E_ZERO;
			term_value = DEFAULT_VALUE;
			expected_bytes.delete();
			outstanding <= 0;
		end else begin
			// a word out always belongs to an earlier list word
			if (out_valid && out_ready)
				check_byte();
			if (cfg_valid && cfg_ready && cfg_index < NUM_VAL)
				term_value[cfg_index[ADDR_W-1:0]] = cfg_data;
			if (in_valid && in_ready)
				predict_word(list_byte, list_end);
			outstanding <= expected_bytes.size();
		end
	end

endmodule

FILE: tb/sv/pdol_data_builder_tb.sv
// ----------------------------------------------------------------------------
// pdol_data_builder_tb
// Feeds data object lists to the related data builder, directed entries
// first and then random lists with random content, under several terminal
// value settings and idling mixes, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module pdol_data_builder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pdb_pkg::*;

	localparam int MAX_RUN = 64;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 47;
	// two-byte tags with fixed zero values
	localparam logic [15:0] T_ZERO_A = 16'h9F5A;
	localparam logic [15:0] T_ZERO_B = 16'h9F03;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       list_byte = 8'h00;
	logic             list_end = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [7:0]       data_byte;
	logic             last_of_run;
	logic             list_done;
	logic             length_clamped;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [VAL_W-1:0] cfg_data = '0;

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	int word_count = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	pdol_data_builder #(
		.MAX_RUN(MAX_RUN)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.list_byte(list_byte),
		.list_end(list_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_byte(data_byte),
		.last_of_run(last_of_run),
		.list_done(list_done),
		.length_clamped(length_clamped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pdol_data_checker #(
		.MAX_RUN(MAX_RUN)
	) i_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.list_byte(list_byte),
		.list_end(list_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_byte(data_byte),
		.last_of_run(last_of_run),
		.list_done(list_done),
		.length_clamped(length_clamped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("pdol_data_builder_tb NOT OK");
		$finish;
	end

	task automatic send_word(input logic [7:0] b, input logic e);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		list_byte <= b;
		list_end <= e;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		word_count++;
	endtask

	// one-byte tags sit in the upper byte of tag
	task automatic send_entry(input logic [15:0] tag, input bit one_byte,
			input logic [7:0] len, input logic e);
		send_word(tag[15:8], 1'b0);
		if (!one_byte)
			send_word(tag[7:0], 1'b0);
		send_word(len, e);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input value_t d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic configure(input int p);
		value_t d;
		for (int r = R_TTI; r <= R_MTI; r++) begin
			case (p)
				0: d = '0;
				1: d = '1;
				default: d = VAL_W'({$urandom, $urandom});
			endcase
			// phase 0 keeps the values from reset
			if (p != 0)
				write_reg(IDX_W'(r), d);
		end
		// index past the last register must change nothing
		d = VAL_W'({$urandom, $urandom});
		write_reg(IDX_W'($urandom_range(2**IDX_W - 1, NUM_VAL)), d);
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_tag(output logic [15:0] tag, output bit one_byte);
		one_byte = 1'b0;
		case ($urandom_range(15))
			0: begin tag = {T_DATE, 8'h00}; one_byte = 1'b1; end
			1: begin tag = {T_TVR, 8'h00}; one_byte = 1'b1; end
			2: begin tag = {T_TYPE, 8'h00}; one_byte = 1'b1; end
			3: begin tag = {T_TCH, 8'h00}; one_byte = 1'b1; end
			4: tag = T_TTI;
			5: tag = T_TTQ;
			6, 7: tag = T_AMT;
			8: tag = T_CTRY;
			9: tag = T_CURR;
			10: tag = T_UN;
			11: tag = T_MTI;
			12: tag = T_ZERO_A;
			13: tag = T_ZERO_B;
			default: begin
				tag = 16'($urandom);
				case (tag[15:8])
					T_DATE, T_TVR, T_TYPE, T_TCH: one_byte = 1'b1;
					default: one_byte = 1'b0;
				endcase
			end
		endcase
	endtask

	function automatic logic [7:0] pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 8'd0;
		if (r < 75)
			return 8'($urandom_range(8, 1));
		if (r < 93)
			return 8'($urandom_range(MAX_RUN, 9));
		return 8'($urandom_range(255, MAX_RUN + 1));
	endfunction

	task automatic send_list();
		int n;
		logic [15:0] tag;
		bit one_byte;
		n = $urandom_range(5, 1);
		for (int i = 0; i < n; i++) begin
			pick_tag(tag, one_byte);
			if ($urandom_range(99) < 6)
				send_word(8'($urandom_range(255)), $urandom_range(99) < 25);
			if ($urandom_range(99) < 5) begin
				// list cut short on a tag byte
				send_word(tag[15:8], 1'b1);
				return;
			end
			send_entry(tag, one_byte, pick_len(), i == n - 1);
		end
	endtask

	task automatic directed_lists();
		// qualifiers tag, run as long as its value
		send_entry(T_TTQ, 1'b0, 8'd4, 1'b0);
		// run longer than the stored value
		send_entry(T_TTI, 1'b0, 8'd8, 1'b0);
		send_entry({T_DATE, 8'h00}, 1'b1, 8'd3, 1'b0);
		// top length on a zero tag, clamped, ends the list
		send_entry({T_TVR, 8'h00}, 1'b1, 8'hFF, 1'b1);
		// unknown tag of extreme bytes with zero length
		send_entry(16'h00FF, 1'b0, 8'd0, 1'b0);
		send_entry(T_AMT, 1'b0, 8'(MAX_RUN + 1), 1'b0);
		// list end on the first and on the second tag byte
		send_word(T_UN[15:8], 1'b1);
		send_word(T_UN[15:8], 1'b0);
		send_word(T_UN[7:0], 1'b1);
		send_entry(T_CURR, 1'b0, 8'(MAX_RUN), 1'b1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int start;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 57; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 57; end
				default: begin gap_pct = 33; stall_pct = 33; end
			endcase
			configure(p);
			if (p == 0)
				directed_lists();
			start = word_count;
			while (word_count - start < WORDS_PER_PHASE)
				send_list();
			drain();
		end
		if (fail_count == 0)
			$display("pdol_data_builder_tb OK");
		else
			$display("pdol_data_builder_tb NOT OK");
		$finish;
	end

endmodule

FILE: filelist.f
sv/pdb_pkg.sv
sv/pdb_value_mem.sv
sv/pdol_data_builder.sv
tb/sv/pdol_data_checker.sv
tb/sv/pdol_data_builder_tb.sv
